// ----- rtl/core/three_frame_motion_mask_top_defines.svh -----
// assertion macros for the three-frame motion mask block
// used by three_frame_motion_mask_top; expects clk and rst_n in scope
`ifndef THREE_FRAME_MOTION_MASK_TOP_DEFINES_SVH
`define THREE_FRAME_MOTION_MASK_TOP_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define TFMM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define TFMM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/tfmm_pkg.sv -----
// shared types, constants and helpers for the three-frame motion mask block
// no dependencies
`default_nettype none

package tfmm_pkg;

    localparam int CHAN_W   = 8;
    localparam int WEIGHT_W = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int FRAMES_W   = 2;

    localparam int IMAGE_WIDTH_DEF  = 320;
    localparam int IMAGE_HEIGHT_DEF = 240;

    localparam logic [WEIGHT_W-1:0] WEIGHT_RED_RST   = 11'd306;
    localparam logic [WEIGHT_W-1:0] WEIGHT_GREEN_RST = 11'd601;
    localparam logic [WEIGHT_W-1:0] WEIGHT_BLUE_RST  = 11'd117;
    localparam logic [CHAN_W-1:0]   THRESHOLD_RST    = 8'd5;
    localparam logic [CHAN_W-1:0]   DEFAULT_COLOR_RST = 8'd0;

    localparam logic [FRAMES_W-1:0] FRAMES_FULL = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WEIGHT_RED    = 3'd0,
        REG_WEIGHT_GREEN  = 3'd1,
        REG_WEIGHT_BLUE   = 3'd2,
        REG_THRESHOLD     = 3'd3,
        REG_DEFAULT_RED   = 3'd4,
        REG_DEFAULT_GREEN = 3'd5,
        REG_DEFAULT_BLUE  = 3'd6
    } cfg_reg_t;

    // one history entry per pixel, newest gray in the lowest bits
    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] prev2;
        logic [CHAN_W-1:0] prev1;
    } hist_entry_t;

    function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                   input logic [CHAN_W-1:0] b);
        abs_diff = (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/tfmm_gray.sv -----
// rgb to gray conversion with programmable weights in units of 1/1024
// depends on tfmm_pkg
`default_nettype none

module tfmm_gray (
    input  wire logic [tfmm_pkg::CHAN_W-1:0]   red,
    input  wire logic [tfmm_pkg::CHAN_W-1:0]   green,
    input  wire logic [tfmm_pkg::CHAN_W-1:0]   blue,
    input  wire logic [tfmm_pkg::WEIGHT_W-1:0] weight_red,
    input  wire logic [tfmm_pkg::WEIGHT_W-1:0] weight_green,
    input  wire logic [tfmm_pkg::WEIGHT_W-1:0] weight_blue,
    output logic      [tfmm_pkg::CHAN_W-1:0]   gray
);

    localparam int PROD_W = tfmm_pkg::WEIGHT_W + tfmm_pkg::CHAN_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int SHIFT  = 10;

    logic [tfmm_pkg::WEIGHT_W-1:0] wr;
    logic [tfmm_pkg::WEIGHT_W-1:0] wg;
    logic [tfmm_pkg::WEIGHT_W-1:0] wb;
    logic [PROD_W-1:0]             prod_r;
    logic [PROD_W-1:0]             prod_g;
    logic [PROD_W-1:0]             prod_b;
    logic [SUM_W-1:0]              sum;
    logic [SUM_W-SHIFT-1:0]        scaled;

    always_comb
    begin
        // all-zero weights fall back to the standard luma weights
        if (weight_red == '0 && weight_green == '0 && weight_blue == '0)
        begin
            wr = tfmm_pkg::WEIGHT_RED_RST;
            wg = tfmm_pkg::WEIGHT_GREEN_RST;
            wb = tfmm_pkg::WEIGHT_BLUE_RST;
        end
        else
        begin
            wr = weight_red;
            wg = weight_green;
            wb = weight_blue;
        end
        prod_r = PROD_W'(wr) * PROD_W'(red);
        prod_g = PROD_W'(wg) * PROD_W'(green);
        prod_b = PROD_W'(wb) * PROD_W'(blue);
        sum    = SUM_W'(prod_r) + SUM_W'(prod_g) + SUM_W'(prod_b);
        scaled = sum[SUM_W-1:SHIFT];
        if (scaled > (SUM_W-SHIFT)'(255))
        begin
            gray = '1;
        end
        else
        begin
            gray = scaled[tfmm_pkg::CHAN_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/tfmm_hist.sv -----
// per-pixel history memory, one write and one registered read port
// depends on tfmm_pkg
`default_nettype none

module tfmm_hist #(
    parameter int DEPTH  = tfmm_pkg::IMAGE_WIDTH_DEF * tfmm_pkg::IMAGE_HEIGHT_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                  clk,
    input  wire logic                  rd_en,
    input  wire logic [ADDR_W-1:0]     rd_addr,
    output tfmm_pkg::hist_entry_t      rd_data,
    input  wire logic                  wr_en,
    input  wire logic [ADDR_W-1:0]     wr_addr,
    input  wire tfmm_pkg::hist_entry_t wr_data
);

    tfmm_pkg::hist_entry_t mem_reg [DEPTH];
    tfmm_pkg::hist_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/core/three_frame_motion_mask_top.sv -----
// three-frame difference motion mask: top level with config, pipeline and tracking
// depends on tfmm_pkg, tfmm_gray, tfmm_hist and three_frame_motion_mask_top_defines.svh
//
// usage
//   s_axis carries one rgb pixel per item in raster order, tdata = {blue, green, red},
//   tuser = start of frame. m_axis returns one item per pixel, tdata = the previous
//   frame color of that pixel when it moves, else the default color; tuser = moving.
//   cfg is a write channel (index, data) that is always ready; write it only while idle.
//   a result passes through stage 1, stage 2 and the output register after its pixel is accepted
//   throughput: one pixel per cycle while m_axis does not stall, set by the single read and
//   write port of the history memory, with each pixel read at accept and written from stage 2;
//   back-to-back hits on the same pixel are forwarded around the memory
//   a stall on m_axis freezes the whole pipeline and drops s_axis_tready in the
//   same cycle; no item is lost
//   reset clears the config registers, the valid flags, the position and the frame
//   count; the history memory is not cleared, and the first two frames after reset give
//   moving = 0 and the default color
`default_nettype none

module three_frame_motion_mask_top #(
    parameter int IMAGE_WIDTH  = tfmm_pkg::IMAGE_WIDTH_DEF,
    parameter int IMAGE_HEIGHT = tfmm_pkg::IMAGE_HEIGHT_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [3*tfmm_pkg::CHAN_W-1:0]       s_axis_tdata,  // pixel_red, pixel_green, pixel_blue
    input  wire logic                                s_axis_tuser,  // start_of_frame
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic      [3*tfmm_pkg::CHAN_W-1:0]       m_axis_tdata,  // out_red, out_green, out_blue
    output logic                                     m_axis_tuser,  // moving
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [tfmm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [tfmm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int PIXEL_COUNT = IMAGE_WIDTH * IMAGE_HEIGHT;
    localparam int POS_W       = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(PIXEL_COUNT - 1);
    localparam int CW = tfmm_pkg::CHAN_W;

    // configuration
    logic [tfmm_pkg::WEIGHT_W-1:0] weight_red_reg;
    logic [tfmm_pkg::WEIGHT_W-1:0] weight_green_reg;
    logic [tfmm_pkg::WEIGHT_W-1:0] weight_blue_reg;
    logic [CW-1:0]                 threshold_reg;
    logic [CW-1:0]                 default_red_reg;
    logic [CW-1:0]                 default_green_reg;
    logic [CW-1:0]                 default_blue_reg;

    // position and frame tracking
    logic [POS_W-1:0]              pos_reg;
    logic [POS_W-1:0]              pos_next;
    logic [tfmm_pkg::FRAMES_W-1:0] frames_reg;
    logic [tfmm_pkg::FRAMES_W-1:0] frames_next;
    logic [tfmm_pkg::FRAMES_W-1:0] frames_adj;
    logic [POS_W-1:0]              pos_cur;
    logic                          sof_restart;
    logic                          end_wrap;
    logic                          warm;

    logic adv;
    logic accept;

    // stage 1: accepted pixel, history read in flight
    logic             s1_valid_reg;
    logic [CW-1:0]    s1_red_reg;
    logic [CW-1:0]    s1_green_reg;
    logic [CW-1:0]    s1_blue_reg;
    logic [POS_W-1:0] s1_pos_reg;
    logic             s1_warm_reg;
    logic             s1_hit_b_reg;
    logic             s1_hit_c_reg;
    tfmm_pkg::hist_entry_t s1_fwd_reg;

    // stage 2: gray and resolved history entry
    logic             s2_valid_reg;
    logic [CW-1:0]    s2_red_reg;
    logic [CW-1:0]    s2_green_reg;
    logic [CW-1:0]    s2_blue_reg;
    logic [POS_W-1:0] s2_pos_reg;
    logic             s2_warm_reg;
    logic [CW-1:0]    s2_gray_reg;
    tfmm_pkg::hist_entry_t s2_entry_reg;

    // output register
    logic          out_valid_reg;
    logic          out_moving_reg;
    logic [CW-1:0] out_red_reg;
    logic [CW-1:0] out_green_reg;
    logic [CW-1:0] out_blue_reg;

    logic [CW-1:0]         s1_gray;
    tfmm_pkg::hist_entry_t rd_entry;
    tfmm_pkg::hist_entry_t wr_entry;
    tfmm_pkg::hist_entry_t s1_entry;
    logic                  moving;
    logic                  wr_en;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_red_reg    <= tfmm_pkg::WEIGHT_RED_RST;
            weight_green_reg  <= tfmm_pkg::WEIGHT_GREEN_RST;
            weight_blue_reg   <= tfmm_pkg::WEIGHT_BLUE_RST;
            threshold_reg     <= tfmm_pkg::THRESHOLD_RST;
            default_red_reg   <= tfmm_pkg::DEFAULT_COLOR_RST;
            default_green_reg <= tfmm_pkg::DEFAULT_COLOR_RST;
            default_blue_reg  <= tfmm_pkg::DEFAULT_COLOR_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                tfmm_pkg::REG_WEIGHT_RED:    weight_red_reg    <= cfg_data;
                tfmm_pkg::REG_WEIGHT_GREEN:  weight_green_reg  <= cfg_data;
                tfmm_pkg::REG_WEIGHT_BLUE:   weight_blue_reg   <= cfg_data;
                tfmm_pkg::REG_THRESHOLD:     threshold_reg     <= cfg_data[CW-1:0];
                tfmm_pkg::REG_DEFAULT_RED:   default_red_reg   <= cfg_data[CW-1:0];
                tfmm_pkg::REG_DEFAULT_GREEN: default_green_reg <= cfg_data[CW-1:0];
                tfmm_pkg::REG_DEFAULT_BLUE:  default_blue_reg  <= cfg_data[CW-1:0];
                default:                     ;
            endcase
        end
    end

    // whole pipeline moves together whenever the output register can take an item
    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign accept        = s_axis_tvalid && adv;

    always_comb
    begin
        sof_restart = s_axis_tuser && (pos_reg != '0);
        pos_cur     = sof_restart ? '0 : pos_reg;
        frames_adj  = (sof_restart && frames_reg != tfmm_pkg::FRAMES_FULL)
                      ? frames_reg + 1'b1 : frames_reg;
        warm        = (frames_adj == tfmm_pkg::FRAMES_FULL);
        end_wrap    = (pos_cur == LAST_POS);
        pos_next    = end_wrap ? '0 : pos_cur + 1'b1;
        frames_next = (end_wrap && frames_adj != tfmm_pkg::FRAMES_FULL)
                      ? frames_adj + 1'b1 : frames_adj;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            frames_reg <= '0;
        end
        else if (accept)
        begin
            pos_reg    <= pos_next;
            frames_reg <= frames_next;
        end
    end

    tfmm_hist #(
        .DEPTH  (PIXEL_COUNT),
        .ADDR_W (POS_W)
    ) u_hist (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (pos_cur),
        .rd_data (rd_entry),
        .wr_en   (wr_en),
        .wr_addr (s2_pos_reg),
        .wr_data (wr_entry)
    );

    tfmm_gray u_gray (
        .red          (s1_red_reg),
        .green        (s1_green_reg),
        .blue         (s1_blue_reg),
        .weight_red   (weight_red_reg),
        .weight_green (weight_green_reg),
        .weight_blue  (weight_blue_reg),
        .gray         (s1_gray)
    );

    // newest pending write to the same pixel wins over the memory data
    always_comb
    begin
        if (s1_hit_b_reg)
        begin
            s1_entry = wr_entry;
        end
        else if (s1_hit_c_reg)
        begin
            s1_entry = s1_fwd_reg;
        end
        else
        begin
            s1_entry = rd_entry;
        end
    end

    always_comb
    begin
        moving = s2_warm_reg &&
                 (tfmm_pkg::abs_diff(s2_gray_reg, s2_entry_reg.prev1) >= threshold_reg) &&
                 (tfmm_pkg::abs_diff(s2_entry_reg.prev1, s2_entry_reg.prev2) >= threshold_reg);
        wr_entry.prev1 = s2_gray_reg;
        wr_entry.prev2 = s2_entry_reg.prev1;
        wr_entry.red   = s2_red_reg;
        wr_entry.green = s2_green_reg;
        wr_entry.blue  = s2_blue_reg;
        wr_en          = adv && s2_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_hit_b_reg  <= 1'b0;
            s1_hit_c_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= accept;
            s1_hit_b_reg  <= accept && s1_valid_reg && (s1_pos_reg == pos_cur);
            s1_hit_c_reg  <= accept && s2_valid_reg && (s2_pos_reg == pos_cur);
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_red_reg     <= s_axis_tdata[CW-1:0];
            s1_green_reg   <= s_axis_tdata[2*CW-1:CW];
            s1_blue_reg    <= s_axis_tdata[3*CW-1:2*CW];
            s1_pos_reg     <= pos_cur;
            s1_warm_reg    <= warm;
            s1_fwd_reg     <= wr_entry;
            s2_red_reg     <= s1_red_reg;
            s2_green_reg   <= s1_green_reg;
            s2_blue_reg    <= s1_blue_reg;
            s2_pos_reg     <= s1_pos_reg;
            s2_warm_reg    <= s1_warm_reg;
            s2_gray_reg    <= s1_gray;
            s2_entry_reg   <= s1_entry;
            out_moving_reg <= moving;
            out_red_reg    <= moving ? s2_entry_reg.red   : default_red_reg;
            out_green_reg  <= moving ? s2_entry_reg.green : default_green_reg;
            out_blue_reg   <= moving ? s2_entry_reg.blue  : default_blue_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_moving_reg;
    assign m_axis_tdata  = {out_blue_reg, out_green_reg, out_red_reg};

`include "three_frame_motion_mask_top_defines.svh"

    `TFMM_ASSERT_NOW(a_moving_after_warmup, m_axis_tvalid && m_axis_tuser,
        frames_reg == tfmm_pkg::FRAMES_FULL, "moving reported before two frames")
    `TFMM_ASSERT_NEXT(a_sof_restarts, accept && s_axis_tuser && pos_reg != '0,
        pos_reg == POS_W'(1), "start of frame did not restart position")
    `TFMM_ASSERT_NEXT(a_frames_monotonic, 1'b1,
        frames_reg >= $past(frames_reg), "frame count went backwards")

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// self-checking testbench for three_frame_motion_mask_top: random rgb pixel frames in,
// motion mask items checked field by field against a predictor of gray, history and warm-up
// depends on tfmm_pkg and the rtl of three_frame_motion_mask_top
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tfmm_pkg::*;

    localparam int PIXEL_COUNT     = IMAGE_WIDTH_DEF * IMAGE_HEIGHT_DEF;
    localparam int MAX_FRAME       = 48;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 170;
    localparam int PRESSURE_PHASE  = 4;
    localparam int QUIET_PHASE     = 6;
    localparam int HOLD_CYCLES     = 300;
    localparam int LATENCY         = 3;
    localparam int DRAIN_CYCLES    = 16;
    localparam int CYCLE_LIMIT     = 1000000;

    localparam int unsigned FALLBACK_RED   = 306;
    localparam int unsigned FALLBACK_GREEN = 601;
    localparam int unsigned FALLBACK_BLUE  = 117;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    localparam logic [8*24-1:0] EXTREMES = {
        24'h808080, 24'h00FFFF, 24'hFFFF00, 24'hFF0000,
        24'h00FF00, 24'h0000FF, 24'hFFFFFF, 24'h000000
    };

    typedef struct packed {
        logic              moving;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } mask_item_t;

    class motion_scoreboard;
        hist_entry_t        history [PIXEL_COUNT];
        logic [WEIGHT_W-1:0] w_red, w_green, w_blue;
        logic [CHAN_W-1:0]   threshold, still_red, still_green, still_blue;
        int unsigned         position;
        int unsigned         frames_done;
        mask_item_t          predicted_masks [$];
        int unsigned         results;
        int unsigned         mismatches;

        function new();
            foreach (history[i])
                history[i] = '0;
            w_red       = WEIGHT_RED_RST;
            w_green     = WEIGHT_GREEN_RST;
            w_blue      = WEIGHT_BLUE_RST;
            threshold   = THRESHOLD_RST;
            still_red   = DEFAULT_COLOR_RST;
            still_green = DEFAULT_COLOR_RST;
            still_blue  = DEFAULT_COLOR_RST;
            position    = 0;
            frames_done = 0;
            results     = 0;
            mismatches  = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_WEIGHT_RED:    w_red = data;
                REG_WEIGHT_GREEN:  w_green = data;
                REG_WEIGHT_BLUE:   w_blue = data;
                REG_THRESHOLD:     threshold = data[CHAN_W-1:0];
                REG_DEFAULT_RED:   still_red = data[CHAN_W-1:0];
                REG_DEFAULT_GREEN: still_green = data[CHAN_W-1:0];
                REG_DEFAULT_BLUE:  still_blue = data[CHAN_W-1:0];
                default:           ;
            endcase
        endfunction

        function logic [CHAN_W-1:0] gray_of(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                                            logic [CHAN_W-1:0] b);
            int unsigned wr, wg, wb, acc;
            wr = w_red;
            wg = w_green;
            wb = w_blue;
            if (wr == 0 && wg == 0 && wb == 0)
            begin
                wr = FALLBACK_RED;
                wg = FALLBACK_GREEN;
                wb = FALLBACK_BLUE;
            end
            acc = (wr * r + wg * g + wb * b) >> 10;
            return (acc > 255) ? 8'd255 : acc[7:0];
        endfunction

        function logic [CHAN_W-1:0] distance(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b);
            return (a > b) ? a - b : b - a;
        endfunction

        function void take_pixel(logic [3*CHAN_W-1:0] rgb, logic sof);
            logic [CHAN_W-1:0] r, g, b, gray;
            hist_entry_t       entry;
            mask_item_t        item;
            r = rgb[7:0];
            g = rgb[15:8];
            b = rgb[23:16];
            if (sof && position != 0)
            begin
                position = 0;
                if (frames_done < 2)
                    frames_done++;
            end
            if (position >= PIXEL_COUNT)
                position = 0;
            gray  = gray_of(r, g, b);
            entry = history[position];
            item.moving = frames_done >= 2 &&
                          distance(gray, entry.prev1) >= threshold &&
                          distance(entry.prev1, entry.prev2) >= threshold;
            item.red   = item.moving ? entry.red : still_red;
            item.green = item.moving ? entry.green : still_green;
            item.blue  = item.moving ? entry.blue : still_blue;
            predicted_masks = {predicted_masks, item};
            entry.prev2 = entry.prev1;
            entry.prev1 = gray;
            entry.red   = r;
            entry.green = g;
            entry.blue  = b;
            history[position] = entry;
            position++;
            if (position >= PIXEL_COUNT)
            begin
                position = 0;
                if (frames_done < 2)
                    frames_done++;
            end
        endfunction

        function void check_mask(logic moving, logic [3*CHAN_W-1:0] rgb);
            mask_item_t want;
            results++;
            if (predicted_masks.size() == 0)
            begin
                if (mismatches < 10)
                    $display("item %0d: unexpected mask item, moving %0b rgb %h", results, moving,
                             rgb);
                mismatches++;
                return;
            end
            want = predicted_masks.pop_front();
            if (moving !== want.moving || rgb[7:0] !== want.red ||
                rgb[15:8] !== want.green || rgb[23:16] !== want.blue)
            begin
                if (mismatches < 10)
                    $display("item %0d: expected moving %0b r %h g %h b %h, got moving %0b r %h g %h b %h",
                             results, want.moving, want.red, want.green, want.blue,
                             moving, rgb[7:0], rgb[15:8], rgb[23:16]);
                mismatches++;
            end
        endfunction

        function int pending();
            return predicted_masks.size();
        endfunction
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [3*CHAN_W-1:0]       s_axis_tdata = '0;  // pixel_red, pixel_green, pixel_blue
    logic                      s_axis_tuser = 1'b0;  // start_of_frame
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [3*CHAN_W-1:0]       m_axis_tdata;  // out_red, out_green, out_blue
    logic                      m_axis_tuser;  // moving
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [CFG_DATA_W-1:0]     cfg_data = '0;

    motion_scoreboard board = new();
    logic [23:0]      scene [MAX_FRAME];
    bit               quiet = 1'b0;
    int               phase = -1;
    int unsigned      cycle_count = 0;

    three_frame_motion_mask_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                board.set_reg(cfg_index, cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                board.take_pixel(s_axis_tdata, s_axis_tuser);
            if (m_axis_tvalid && m_axis_tready)
                board.check_mask(m_axis_tuser, m_axis_tdata);
        end
    end

    // receiver, with one long hold-off so the pipeline backs up
    initial
    begin
        bit held;
        held = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held && phase == PRESSURE_PHASE)
            begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_axis_tready <= quiet || ($urandom_range(99) >= 26);
        end
    end

    task automatic send_pixel(input logic [23:0] rgb, input logic sof);
        while (!quiet && $urandom_range(99) < 26)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rgb;
        s_axis_tuser  <= sof;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic program_regs(input logic [CFG_DATA_W-1:0] wr, input logic [CFG_DATA_W-1:0] wg,
                                input logic [CFG_DATA_W-1:0] wb, input logic [CHAN_W-1:0] th,
                                input logic [CHAN_W-1:0] dr, input logic [CHAN_W-1:0] dg,
                                input logic [CHAN_W-1:0] db);
        write_reg(REG_WEIGHT_RED, wr);
        write_reg(REG_WEIGHT_GREEN, wg);
        write_reg(REG_WEIGHT_BLUE, wb);
        write_reg(REG_THRESHOLD, th);
        write_reg(REG_DEFAULT_RED, dr);
        write_reg(REG_DEFAULT_GREEN, dg);
        write_reg(REG_DEFAULT_BLUE, db);
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        while (board.pending() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    // mostly still or slightly drifting pixels, some replaced outright
    function automatic logic [23:0] next_color(int p);
        logic [23:0] c;
        int          roll;
        int          v;
        c    = scene[p];
        roll = $urandom_range(99);
        if (roll >= 70)
            c = 24'($urandom);
        else if (roll >= 35)
            for (int k = 0; k < 3; k++)
            begin
                v = int'(c[8*k +: 8]) + int'($urandom_range(24)) - 12;
                if (v < 0)
                    v = 0;
                if (v > 255)
                    v = 255;
                c[8*k +: 8] = v[7:0];
            end
        scene[p] = c;
        return c;
    endfunction

    initial
    begin
        logic [23:0]         c;
        int                  sent;
        int                  len;
        logic [WEIGHT_W-1:0] wr, wg;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // warm-up: two frames of the longest length so every later pixel has history
        for (int f = 0; f < 2; f++)
            for (int p = 0; p < MAX_FRAME; p++)
            begin
                c = 24'($urandom);
                scene[p] = c;
                send_pixel(c, p == 0);
            end

        // extremes: even pixels flip between a color and its complement
        for (int d = 0; d < 3; d++)
            for (int p = 0; p < 8; p++)
            begin
                c = EXTREMES[24*p +: 24];
                if (p % 2 == 0 && d % 2 == 1)
                    c = ~c;
                scene[p] = c;
                send_pixel(c, p == 0);
            end
        s_axis_tvalid <= 1'b0;

        for (int k = 0; k < NUM_PHASES; k++)
        begin
            settle();
            case (k)
                0:
                begin
                    write_reg(REG_SPARE, 11'h7FF);
                    program_regs(11'd0, 11'd0, 11'd0, 8'd0, 8'd255, 8'd0, 8'd255);
                end
                1: program_regs(11'd1024, 11'd1024, 11'd1024, 8'd255, 8'd255, 8'd255, 8'd255);
                2: program_regs(11'h7FF, 11'h7FF, 11'h7FF, 8'd1, 8'd0, 8'd0, 8'd0);
                default:
                begin
                    if ($urandom_range(3) == 0)
                        program_regs(CFG_DATA_W'($urandom_range(2047)),
                                     CFG_DATA_W'($urandom_range(2047)),
                                     CFG_DATA_W'($urandom_range(2047)),
                                     CHAN_W'($urandom_range(255)),
                                     CHAN_W'($urandom_range(255)),
                                     CHAN_W'($urandom_range(255)),
                                     CHAN_W'($urandom_range(255)));
                    else
                    begin
                        wr = WEIGHT_W'($urandom_range(1024));
                        wg = WEIGHT_W'($urandom_range(1024 - wr));
                        program_regs(wr, wg, 11'd1024 - wr - wg,
                                     CHAN_W'($urandom_range(24)),
                                     CHAN_W'($urandom_range(255)),
                                     CHAN_W'($urandom_range(255)),
                                     CHAN_W'($urandom_range(255)));
                    end
                end
            endcase
            quiet = (k == QUIET_PHASE);
            phase = k;
            sent  = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                len = ($urandom_range(9) == 0) ? 1 : $urandom_range(MAX_FRAME, 2);
                for (int p = 0; p < len; p++)
                begin
                    c = next_color(p);
                    send_pixel(c, p == 0);
                    sent++;
                end
            end
            s_axis_tvalid <= 1'b0;
        end
        quiet = 1'b0;

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
